@@ rtl/mcfam_pkg.sv @@
// Shared types and constants for the mic capture FIFO and audio mixer unit.
// Holds the command codes, register bit positions and transaction structs.
// No dependencies.
package mcfam_pkg;

  // Command codes carried in the cmd field of an input transaction
  typedef enum logic [2:0] {
    CMD_WR_MIC  = 3'd0,
    CMD_RD_MIC  = 3'd1,
    CMD_POP_MIC = 3'd2,
    CMD_WR_SND  = 3'd3,
    CMD_RD_SND  = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_e;

  // Register masks
  localparam logic [15:0] CTRL_KEEP_MASK = 16'hE00F;  // bits that are stored
  localparam logic [15:0] MIC_LOCK_MASK  = 16'h100F;  // ignored while mic enabled

  // Mic control bit positions
  localparam int unsigned MIC_OVR_BIT    = 11;
  localparam int unsigned MIC_CLR_BIT    = 12;
  localparam int unsigned MIC_HALF_IE    = 13;
  localparam int unsigned MIC_OVR_IE     = 14;
  localparam int unsigned MIC_EN_BIT     = 15;
  localparam int unsigned MIC_EMPTY_BIT  = 8;
  localparam int unsigned MIC_HALF_BIT   = 9;
  localparam int unsigned MIC_FULL_BIT   = 10;

  // Sound control bit positions
  localparam int unsigned SND_RATE_BIT   = 13;
  localparam int unsigned SND_MUTE_BIT   = 14;
  localparam int unsigned SND_EN_BIT     = 15;

  // Mic sample formats
  localparam logic [1:0] FMT_DUP   = 2'd0;
  localparam logic [1:0] FMT_DECIM = 2'd2;
  localparam logic [1:0] FMT_OFF   = 2'd3;

  // Mix ratio full scale
  localparam logic [3:0] MIX_FULL = 4'd8;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [15:0]        wdata;
    logic [15:0]        wmask;
    logic signed [15:0] main_left;
    logic signed [15:0] main_right;
    logic signed [15:0] dsp_left;
    logic signed [15:0] dsp_right;
    logic signed [15:0] mic_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        rdata;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               irq;
    logic               dma_request;
    logic               mic_start;
    logic               mic_stop;
    logic               rate_changed;
    logic               rate_high;
  } out_item_t;

endpackage

@@ rtl/mcfam_mix.sv @@
// Stereo mixer: blends main and DSP sources at ratio n/8, n clamped to 8.
// Pure combinational; depends on mcfam_pkg for the full-scale constant.
module mcfam_mix (
  input  logic [3:0]         ratio_i,
  input  logic signed [15:0] main_left_i,
  input  logic signed [15:0] main_right_i,
  input  logic signed [15:0] dsp_left_i,
  input  logic signed [15:0] dsp_right_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o
);

  logic [3:0]         fn;
  logic [3:0]         fd;
  logic signed [19:0] fn_s;
  logic signed [19:0] fd_s;
  logic signed [19:0] ml_x, mr_x, dl_x, dr_x;
  logic signed [19:0] sum_l, sum_r;
  logic signed [19:0] shr_l, shr_r;

  // Clamp the ratio and form the complementary weight
  assign fn   = (ratio_i > mcfam_pkg::MIX_FULL) ? mcfam_pkg::MIX_FULL : ratio_i;
  assign fd   = mcfam_pkg::MIX_FULL - fn;
  assign fn_s = $signed({16'b0, fn});
  assign fd_s = $signed({16'b0, fd});

  // Sign-extend the sources
  assign ml_x = $signed({{4{main_left_i[15]}},  main_left_i});
  assign mr_x = $signed({{4{main_right_i[15]}}, main_right_i});
  assign dl_x = $signed({{4{dsp_left_i[15]}},   dsp_left_i});
  assign dr_x = $signed({{4{dsp_right_i[15]}},  dsp_right_i});

  // Weighted sum, then floor divide by 8
  assign sum_l = ml_x * fn_s + dl_x * fd_s;
  assign sum_r = mr_x * fn_s + dr_x * fd_s;
  assign shr_l = sum_l >>> 3;
  assign shr_r = sum_r >>> 3;

  assign out_left_o  = shr_l[15:0];
  assign out_right_o = shr_r[15:0];

endmodule

@@ rtl/mic_capture_fifo_and_audio_mixer_unit.sv @@
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the result channel is not stalled,
// set by the single-pass update between the registers and a FIFO memory with one
// write and one read port feeding a prefetched head word.
// Reset: asynchronous, active low; clears control registers, FIFO pointers and level,
// held sample and last popped word, not FIFO contents. Needs mcfam_pkg, mcfam_mix.
module mic_capture_fifo_and_audio_mixer_unit #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mcfam_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mcfam_pkg::out_item_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
  localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(FIFO_DEPTH / 2);

  // Pipeline registers
  logic                 s1_valid_q;
  mcfam_pkg::in_item_t  s1_q;
  logic                 out_valid_q;
  mcfam_pkg::out_item_t out_q;
  logic                 advance;

  // Architectural state
  logic [15:0]      mic_ctrl_q, mic_ctrl_d;
  logic [15:0]      snd_ctrl_q, snd_ctrl_d;
  logic [1:0]       rate_div_q, rate_div_d;
  logic [15:0]      held_q, held_d;
  logic             held_valid_q, held_valid_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [31:0]      last_word_q, last_word_d;

  // FIFO memory and prefetched head word
  logic [31:0]      mem [FIFO_DEPTH];
  logic [31:0]      head_q;
  logic             mem_we;
  logic [31:0]      mem_wdata;

  // Working signals
  mcfam_pkg::out_item_t res;
  logic [15:0]      wm;
  logic [15:0]      mval;
  logic [15:0]      sval;
  logic [15:0]      rd_flags;
  logic [1:0]       mode;
  logic [1:0]       rate;
  logic [1:0]       chk;
  logic             feed_en;
  logic             capture;
  logic             ovr_new;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;

  // Handshake: hold the input stage while the result register is blocked
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mcfam_mix u_mix (
    .ratio_i      (snd_ctrl_q[3:0]),
    .main_left_i  (s1_q.main_left),
    .main_right_i (s1_q.main_right),
    .dsp_left_i   (s1_q.dsp_left),
    .dsp_right_i  (s1_q.dsp_right),
    .out_left_o   (mix_left),
    .out_right_o  (mix_right)
  );

  // Status flags added on a mic control read
  always_comb begin
    rd_flags = '0;
    rd_flags[mcfam_pkg::MIC_EMPTY_BIT] = (level_q == '0);
    rd_flags[mcfam_pkg::MIC_HALF_BIT]  = (level_q >= LVL_HALF);
    rd_flags[mcfam_pkg::MIC_FULL_BIT]  = (level_q >= LVL_FULL);
  end

  // Mic path decode
  assign mode    = mic_ctrl_q[1:0];
  assign rate    = mic_ctrl_q[3:2];
  assign chk     = (mode == mcfam_pkg::FMT_DECIM) ? rate : 2'd0;
  assign feed_en = mic_ctrl_q[mcfam_pkg::MIC_EN_BIT] && !mic_ctrl_q[mcfam_pkg::MIC_OVR_BIT]
                   && (mode != mcfam_pkg::FMT_OFF);
  assign capture = (rate_div_q == chk);
  assign wm      = mic_ctrl_q[mcfam_pkg::MIC_EN_BIT] ?
                   (s1_q.wmask & ~mcfam_pkg::MIC_LOCK_MASK) : s1_q.wmask;
  assign mval    = (s1_q.wdata & wm) | (mic_ctrl_q & ~wm);

  // Single-pass update of state and result for the transaction in the input stage
  always_comb begin
    mic_ctrl_d   = mic_ctrl_q;
    snd_ctrl_d   = snd_ctrl_q;
    rate_div_d   = rate_div_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    level_d      = level_q;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    last_word_d  = last_word_q;
    mem_we       = 1'b0;
    mem_wdata    = {s1_q.mic_sample, s1_q.mic_sample};
    ovr_new      = 1'b0;
    sval         = (s1_q.wdata & s1_q.wmask) | (snd_ctrl_q & ~s1_q.wmask);
    res          = '0;

    if (advance) begin
      case (s1_q.cmd)
        mcfam_pkg::CMD_WR_MIC: begin
          if (mval[mcfam_pkg::MIC_CLR_BIT]) begin
            level_d      = '0;
            rptr_d       = '0;
            wptr_d       = '0;
            held_d       = '0;
            held_valid_d = 1'b0;
          end
          if (mval[mcfam_pkg::MIC_EN_BIT] != mic_ctrl_q[mcfam_pkg::MIC_EN_BIT]) begin
            if (mval[mcfam_pkg::MIC_EN_BIT]) begin
              rate_div_d    = '0;
              held_valid_d  = 1'b0;
              res.mic_start = 1'b1;
            end else begin
              res.mic_stop = 1'b1;
            end
          end
          mic_ctrl_d = mval & mcfam_pkg::CTRL_KEEP_MASK;
          mic_ctrl_d[mcfam_pkg::MIC_OVR_BIT] = mic_ctrl_q[mcfam_pkg::MIC_OVR_BIT]
                                               && !mval[mcfam_pkg::MIC_CLR_BIT];
        end
        mcfam_pkg::CMD_RD_MIC: begin
          res.rdata = {16'b0, mic_ctrl_q | rd_flags};
        end
        mcfam_pkg::CMD_POP_MIC: begin
          if (level_q != '0) begin
            last_word_d = head_q;
            rptr_d      = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
            level_d     = level_q - 1'b1;
            res.rdata   = head_q;
          end else begin
            res.rdata = last_word_q;
          end
        end
        mcfam_pkg::CMD_WR_SND: begin
          if (snd_ctrl_q[mcfam_pkg::SND_EN_BIT]) begin
            sval[mcfam_pkg::SND_RATE_BIT] = snd_ctrl_q[mcfam_pkg::SND_RATE_BIT];
          end
          res.rate_changed = sval[mcfam_pkg::SND_RATE_BIT]
                             ^ snd_ctrl_q[mcfam_pkg::SND_RATE_BIT];
          snd_ctrl_d = sval & mcfam_pkg::CTRL_KEEP_MASK;
        end
        mcfam_pkg::CMD_RD_SND: begin
          res.rdata = {16'b0, snd_ctrl_q};
        end
        mcfam_pkg::CMD_TICK: begin
          if (snd_ctrl_q[mcfam_pkg::SND_EN_BIT]) begin
            // Mix or mute the output
            if (!snd_ctrl_q[mcfam_pkg::SND_MUTE_BIT]) begin
              res.out_left  = mix_left;
              res.out_right = mix_right;
            end
            // Feed the mic sample through the decimator and packer
            if (feed_en) begin
              rate_div_d = (rate_div_q >= rate) ? 2'd0 : rate_div_q + 2'd1;
              if (capture && (mode != mcfam_pkg::FMT_DUP) && !held_valid_q) begin
                // First half of a pair: hold it, no flags on this tick
                held_d       = s1_q.mic_sample;
                held_valid_d = 1'b1;
              end else begin
                if (capture) begin
                  held_valid_d = 1'b0;
                  if (mode != mcfam_pkg::FMT_DUP) begin
                    mem_wdata = {s1_q.mic_sample, held_q};
                  end
                  if (level_q >= LVL_FULL) begin
                    ovr_new = 1'b1;
                  end else begin
                    mem_we  = 1'b1;
                    wptr_d  = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
                    level_d = level_q + 1'b1;
                  end
                end
                if (ovr_new) begin
                  mic_ctrl_d[mcfam_pkg::MIC_OVR_BIT] = 1'b1;
                  res.irq      = mic_ctrl_q[mcfam_pkg::MIC_OVR_IE];
                  res.mic_stop = 1'b1;
                end else if (level_d == LVL_HALF) begin
                  res.irq         = mic_ctrl_q[mcfam_pkg::MIC_HALF_IE];
                  res.dma_request = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          res.rdata = '0;
        end
      endcase
    end
    res.rate_high = snd_ctrl_d[mcfam_pkg::SND_RATE_BIT];
  end

  // Input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // Control and status state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_ctrl_q   <= '0;
      snd_ctrl_q   <= '0;
      rate_div_q   <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      level_q      <= '0;
      rptr_q       <= '0;
      wptr_q       <= '0;
      last_word_q  <= '0;
    end else begin
      mic_ctrl_q   <= mic_ctrl_d;
      snd_ctrl_q   <= snd_ctrl_d;
      rate_div_q   <= rate_div_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      level_q      <= level_d;
      rptr_q       <= rptr_d;
      wptr_q       <= wptr_d;
      last_word_q  <= last_word_d;
    end
  end

  // FIFO memory: write at the write pointer, prefetch the next head word
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wptr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && (wptr_q == rptr_d)) begin
      head_q <= mem_wdata;
    end else begin
      head_q <= mem[rptr_d];
    end
  end

endmodule

@@ tb/mic_capture_fifo_and_audio_mixer_unit_tb.sv @@
// Testbench for mic_capture_fifo_and_audio_mixer_unit: directed and random register,
// mic pop and sample tick transactions, checked against a scoreboard that predicts results.
// Depends on mcfam_pkg and the unit's RTL; needs no files or arguments.
`timescale 1ns / 100ps
module mic_capture_fifo_and_audio_mixer_unit_tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;

  // Command codes the block ignores, and the paired mic format code
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [1:0] FMT_PAIR = 2'd1;

  // Register bit patterns
  localparam logic [15:0] ALL_BITS    = 16'hFFFF;
  localparam logic [15:0] LOW_FIELDS  = 16'h000F;
  localparam logic [15:0] MIC_UNUSED  = 16'h0FF0;
  localparam logic [15:0] SND_UNUSED  = 16'h1FF0;
  localparam logic [15:0] B_MIC_EN    = 16'h0001 << mcfam_pkg::MIC_EN_BIT;
  localparam logic [15:0] B_MIC_CLR   = 16'h0001 << mcfam_pkg::MIC_CLR_BIT;
  localparam logic [15:0] B_MIC_OVR   = 16'h0001 << mcfam_pkg::MIC_OVR_BIT;
  localparam logic [15:0] B_MIC_HIE   = 16'h0001 << mcfam_pkg::MIC_HALF_IE;
  localparam logic [15:0] B_MIC_OIE   = 16'h0001 << mcfam_pkg::MIC_OVR_IE;
  localparam logic [15:0] B_SND_EN    = 16'h0001 << mcfam_pkg::SND_EN_BIT;
  localparam logic [15:0] B_SND_MUTE  = 16'h0001 << mcfam_pkg::SND_MUTE_BIT;
  localparam logic [15:0] B_SND_RATE  = 16'h0001 << mcfam_pkg::SND_RATE_BIT;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  // Predicts each result of the unit and checks the results in order
  class audio_unit_scoreboard;
    logic [15:0] mic_ctl;
    logic [15:0] snd_ctl;
    logic [1:0]  divider;
    logic [15:0] held;
    bit          held_ok;
    logic [31:0] words[DEPTH];
    int unsigned level;
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    logic [31:0] last_popped;
    mcfam_pkg::out_item_t results_due[$];
    int unsigned mismatches;
    int unsigned n_checked, n_ticks, n_pops, n_half, n_overruns;

    function new();
      mic_ctl = '0;
      snd_ctl = '0;
      divider = '0;
      held = '0;
      held_ok = 0;
      level = 0;
      rd_ptr = 0;
      wr_ptr = 0;
      last_popped = '0;
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction

    // floor((a*w + b*(8-w)) / 8)
    function logic [15:0] blend(logic signed [15:0] src_a, logic signed [15:0] src_b,
                                int weight);
      int acc;
      acc = int'(src_a) * weight + int'(src_b) * (int'(mcfam_pkg::MIX_FULL) - weight);
      acc = acc >>> 3;
      return acc[15:0];
    endfunction

    // Feed one mic sample; returns {mic_stop, dma_request, irq}
    function logic [2:0] capture_mic(logic [15:0] sample);
      logic [1:0]  fmt, rate, due_at;
      logic [31:0] word;
      logic        take;
      logic [2:0]  flags;
      flags = '0;
      if (!mic_ctl[mcfam_pkg::MIC_EN_BIT] || mic_ctl[mcfam_pkg::MIC_OVR_BIT]) return '0;
      fmt = mic_ctl[1:0];
      rate = mic_ctl[3:2];
      if (fmt == mcfam_pkg::FMT_OFF) return '0;
      due_at = (fmt == mcfam_pkg::FMT_DECIM) ? rate : 2'd0;
      take = (divider == due_at);
      divider = (divider >= rate) ? 2'd0 : divider + 2'd1;
      if (take) begin
        if (fmt == mcfam_pkg::FMT_DUP) begin
          word = {sample, sample};
        end else if (!held_ok) begin
          held = sample;
          held_ok = 1;
          return '0;
        end else begin
          word = {sample, held};
        end
        if (level >= DEPTH) begin
          mic_ctl[mcfam_pkg::MIC_OVR_BIT] = 1'b1;
        end else begin
          words[wr_ptr] = word;
          wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
          level++;
        end
        held_ok = 0;
      end
      if (mic_ctl[mcfam_pkg::MIC_OVR_BIT]) begin
        flags[0] = mic_ctl[mcfam_pkg::MIC_OVR_IE];
        flags[2] = 1'b1;
        n_overruns++;
      end else if (level == DEPTH / 2) begin
        flags[0] = mic_ctl[mcfam_pkg::MIC_HALF_IE];
        flags[1] = 1'b1;
        n_half++;
      end
      return flags;
    endfunction

    function mcfam_pkg::out_item_t predict_result(mcfam_pkg::in_item_t it);
      mcfam_pkg::out_item_t r;
      logic [15:0] mask, val;
      logic [2:0]  flags;
      int          weight;
      r = '0;
      case (it.cmd)
        mcfam_pkg::CMD_WR_MIC: begin
          mask = it.wmask;
          if (mic_ctl[mcfam_pkg::MIC_EN_BIT]) mask = mask & ~mcfam_pkg::MIC_LOCK_MASK;
          val = (it.wdata & mask) | (mic_ctl & ~mask);
          if (val[mcfam_pkg::MIC_CLR_BIT]) begin
            mic_ctl[mcfam_pkg::MIC_OVR_BIT] = 1'b0;
            level = 0;
            rd_ptr = 0;
            wr_ptr = 0;
            held = '0;
            held_ok = 0;
          end
          if (val[mcfam_pkg::MIC_EN_BIT] != mic_ctl[mcfam_pkg::MIC_EN_BIT]) begin
            if (val[mcfam_pkg::MIC_EN_BIT]) begin
              divider = '0;
              held_ok = 0;
              r.mic_start = 1'b1;
            end else begin
              r.mic_stop = 1'b1;
            end
          end
          mic_ctl = (val & mcfam_pkg::CTRL_KEEP_MASK) | (mic_ctl & B_MIC_OVR);
        end
        mcfam_pkg::CMD_RD_MIC: begin
          r.rdata = {16'h0000, mic_ctl};
          r.rdata[mcfam_pkg::MIC_EMPTY_BIT] = (level == 0);
          r.rdata[mcfam_pkg::MIC_HALF_BIT] = (level >= DEPTH / 2);
          r.rdata[mcfam_pkg::MIC_FULL_BIT] = (level >= DEPTH);
        end
        mcfam_pkg::CMD_POP_MIC: begin
          n_pops++;
          if (level > 0) begin
            last_popped = words[rd_ptr];
            rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
            level--;
          end
          r.rdata = last_popped;
        end
        mcfam_pkg::CMD_WR_SND: begin
          val = (it.wdata & it.wmask) | (snd_ctl & ~it.wmask);
          if (snd_ctl[mcfam_pkg::SND_EN_BIT]) begin
            val[mcfam_pkg::SND_RATE_BIT] = snd_ctl[mcfam_pkg::SND_RATE_BIT];
          end
          r.rate_changed = (val[mcfam_pkg::SND_RATE_BIT] != snd_ctl[mcfam_pkg::SND_RATE_BIT]);
          snd_ctl = val & mcfam_pkg::CTRL_KEEP_MASK;
        end
        mcfam_pkg::CMD_RD_SND: begin
          r.rdata = {16'h0000, snd_ctl};
        end
        mcfam_pkg::CMD_TICK: begin
          n_ticks++;
          if (snd_ctl[mcfam_pkg::SND_EN_BIT]) begin
            flags = capture_mic(it.mic_sample);
            r.irq = flags[0];
            r.dma_request = flags[1];
            r.mic_stop = flags[2];
            if (!snd_ctl[mcfam_pkg::SND_MUTE_BIT]) begin
              weight = (snd_ctl[3:0] > mcfam_pkg::MIX_FULL) ? int'(mcfam_pkg::MIX_FULL)
                                                            : int'(snd_ctl[3:0]);
              r.out_left = blend(it.main_left, it.dsp_left, weight);
              r.out_right = blend(it.main_right, it.dsp_right, weight);
            end
          end
        end
        default: ;
      endcase
      r.rate_high = snd_ctl[mcfam_pkg::SND_RATE_BIT];
      return r;
    endfunction

    function void note_input(mcfam_pkg::in_item_t it);
      results_due.push_back(predict_result(it));
    endfunction

    function void compare_field(string fld, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %h actual %h", $time, fld, want, got);
      end
    endfunction

    function void check_result(mcfam_pkg::out_item_t got);
      mcfam_pkg::out_item_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: expected none actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      n_checked++;
      compare_field("rdata", want.rdata, got.rdata);
      compare_field("out_left", want.out_left, got.out_left);
      compare_field("out_right", want.out_right, got.out_right);
      compare_field("irq", want.irq, got.irq);
      compare_field("dma_request", want.dma_request, got.dma_request);
      compare_field("mic_start", want.mic_start, got.mic_start);
      compare_field("mic_stop", want.mic_stop, got.mic_stop);
      compare_field("rate_changed", want.rate_changed, got.rate_changed);
      compare_field("rate_high", want.rate_high, got.rate_high);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  mcfam_pkg::in_item_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  mcfam_pkg::out_item_t out_data_o;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 67;
  int unsigned accepted_items = 0;
  int unsigned cycle_count = 0;
  audio_unit_scoreboard sb = new();

  mic_capture_fifo_and_audio_mixer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, sb.outstanding());
      $display("mic_capture_fifo_and_audio_mixer_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return S_MIN;
    if (pick == 1) return S_MAX;
    if (pick == 2) return 16'sh0000;
    return 16'($urandom);
  endfunction

  function automatic mcfam_pkg::in_item_t reg_access(logic [2:0] cmd, logic [15:0] wdata,
                                                     logic [15:0] wmask);
    mcfam_pkg::in_item_t it;
    it.cmd = cmd;
    it.wdata = wdata;
    it.wmask = wmask;
    it.main_left = rand_sample();
    it.main_right = rand_sample();
    it.dsp_left = rand_sample();
    it.dsp_right = rand_sample();
    it.mic_sample = rand_sample();
    return it;
  endfunction

  function automatic mcfam_pkg::in_item_t tick_with(logic signed [15:0] ml,
                                                    logic signed [15:0] mr,
                                                    logic signed [15:0] dl,
                                                    logic signed [15:0] dr,
                                                    logic signed [15:0] mic);
    mcfam_pkg::in_item_t it;
    it = reg_access(mcfam_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
    it.main_left = ml;
    it.main_right = mr;
    it.dsp_left = dl;
    it.dsp_right = dr;
    it.mic_sample = mic;
    return it;
  endfunction

  // Present one transaction, hold it until accepted, then log it
  task automatic send_transaction(input mcfam_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (it.cmd <= mcfam_pkg::CMD_TICK) accepted_items++;
  endtask

  // Hold off the input until every predicted result has been checked
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic run_directed();
    send_transaction(reg_access(mcfam_pkg::CMD_RD_MIC, '0, '0));
    send_transaction(reg_access(mcfam_pkg::CMD_POP_MIC, '0, '0));
    // sound interface still disabled
    send_transaction(tick_with(S_MAX, S_MIN, S_MIN, S_MAX, 16'sh1234));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_SND,
                                B_SND_EN | B_SND_RATE | 16'(mcfam_pkg::MIX_FULL), ALL_BITS));
    send_transaction(tick_with(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, '0, LOW_FIELDS));
    send_transaction(tick_with(S_MAX, S_MIN, S_MIN, S_MAX, S_MAX));
    // rate bit locked while enabled; ratio above full scale clamps
    send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, LOW_FIELDS, B_SND_RATE | LOW_FIELDS));
    send_transaction(tick_with(S_MIN, S_MIN, S_MAX, S_MAX, '0));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, B_SND_MUTE, B_SND_MUTE));
    send_transaction(tick_with(S_MAX, S_MAX, S_MAX, S_MAX, '0));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, 16'd3, B_SND_MUTE | LOW_FIELDS));
    // paired capture, then a write to locked fields
    send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC,
                                B_MIC_EN | B_MIC_HIE | B_MIC_OIE | 16'(FMT_PAIR), ALL_BITS));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, B_MIC_CLR | LOW_FIELDS,
                                B_MIC_CLR | LOW_FIELDS));
    send_transaction(tick_with(-16'sd1, 16'sd1, 16'sd100, -16'sd100, S_MIN));
    send_transaction(tick_with(S_MAX, S_MIN, 16'sd7, -16'sd7, S_MAX));
    send_transaction(reg_access(mcfam_pkg::CMD_RD_MIC, '0, '0));
    send_transaction(reg_access(mcfam_pkg::CMD_POP_MIC, '0, '0));
    // empty pop repeats the last word
    send_transaction(reg_access(mcfam_pkg::CMD_POP_MIC, '0, '0));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, '0, B_MIC_EN));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, B_MIC_CLR | 16'(mcfam_pkg::FMT_OFF),
                                B_MIC_CLR | LOW_FIELDS));
    send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, B_MIC_EN, B_MIC_EN));
    send_transaction(tick_with(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX));
    send_transaction(reg_access(CMD_SPARE_6, ALL_BITS, ALL_BITS));
    send_transaction(reg_access(CMD_SPARE_7, ALL_BITS, ALL_BITS));
    send_transaction(reg_access(mcfam_pkg::CMD_RD_SND, '0, '0));
  endtask

  // Maybe restart capture, maybe retune the mixer, then stream ticks, pops and register reads
  task automatic run_session();
    logic [15:0] ctl;
    logic [1:0]  fmt;
    int unsigned len, pop_pct, pick, i;
    if ($urandom_range(99) < 85) begin
      send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, '0, B_MIC_EN));
      fmt = ($urandom_range(9) == 0) ? mcfam_pkg::FMT_OFF : 2'($urandom_range(2));
      ctl = B_MIC_EN | B_MIC_CLR | {12'h000, 2'($urandom), fmt} | (16'($urandom) & MIC_UNUSED);
      if ($urandom_range(1)) ctl = ctl | B_MIC_HIE;
      if ($urandom_range(1)) ctl = ctl | B_MIC_OIE;
      send_transaction(reg_access(mcfam_pkg::CMD_WR_MIC, ctl, ALL_BITS));
    end
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(1)) send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, '0, B_SND_EN));
      ctl = B_SND_EN | 16'($urandom_range(15)) | (16'($urandom) & SND_UNUSED);
      if ($urandom_range(99) < 12) ctl = ctl | B_SND_MUTE;
      send_transaction(reg_access(mcfam_pkg::CMD_WR_SND, ctl, ALL_BITS));
    end
    case ($urandom_range(3))
      0: pop_pct = 0;
      1: pop_pct = 15;
      2: pop_pct = 35;
      default: pop_pct = 55;
    endcase
    len = ($urandom_range(9) == 0) ? 150 : $urandom_range(4, 48);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < pop_pct)
        send_transaction(reg_access(mcfam_pkg::CMD_POP_MIC, 16'($urandom), 16'($urandom)));
      else if (pick < pop_pct + 8)
        send_transaction(reg_access(mcfam_pkg::CMD_RD_MIC, 16'($urandom), 16'($urandom)));
      else if (pick < pop_pct + 10)
        send_transaction(reg_access(mcfam_pkg::CMD_RD_SND, 16'($urandom), 16'($urandom)));
      else
        send_transaction(tick_with(rand_sample(), rand_sample(), rand_sample(),
                                   rand_sample(), rand_sample()));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = accepted_items + count;
    while (accepted_items < target) begin
      if ($urandom_range(99) < 78)
        run_session();
      else
        send_transaction(reg_access(3'($urandom_range(7)), 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_for_drain();
    run_random(RANDOM_ITEMS / 3);
    wait_for_drain();
    send_idle_pct = 67;
    recv_idle_pct = 33;
    run_random(RANDOM_ITEMS / 3);
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS / 3);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d results over %0d transactions: %0d ticks, %0d pops,", sb.n_checked,
             accepted_items, sb.n_ticks, sb.n_pops);
    $display("%0d half-level events, %0d overruns, %0d mismatches", sb.n_half,
             sb.n_overruns, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("mic_capture_fifo_and_audio_mixer_unit_tb: PASS");
    end else begin
      $display("mic_capture_fifo_and_audio_mixer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ mic_capture_fifo_and_audio_mixer_unit.f @@
rtl/mcfam_pkg.sv
rtl/mcfam_mix.sv
rtl/mic_capture_fifo_and_audio_mixer_unit.sv
tb/mic_capture_fifo_and_audio_mixer_unit_tb.sv
